// File: rtl/bal_pkg.sv
`default_nettype none

package bal_pkg;

  localparam int CAPACITY = 32;

  // Field widths of one item
  localparam int CMD_W    = 3;
  localparam int POS_W    = 6;
  localparam int AGE_W    = 8;
  localparam int ID_W     = 31;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int YEAR_W   = 12;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 6;

  // Width of the count, of an entry index, and of the index compare
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 8;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT  = 3'd0,
    CMD_INS_REAR   = 3'd1,
    CMD_INS_INDEX  = 3'd2,
    CMD_INS_SORTED = 3'd3,
    CMD_DEL_FRONT  = 3'd4,
    CMD_DEL_REAR   = 3'd5,
    CMD_DEL_INDEX  = 3'd6,
    CMD_READ       = 3'd7
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // One record, age in the lowest bits
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [ID_W-1:0]    id;
    logic [AGE_W-1:0]   age;
  } rec_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;  // capture the accepted item
    logic find;  // register the age compares for a sorted insert
    logic exec;  // apply the operation and load the result register
  } dp_cmd_t;

endpackage

`default_nettype wire

// File: rtl/bal_ctrl.sv
`default_nettype none

module bal_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output bal_pkg::dp_cmd_t      dp_cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_FIND = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    dp_cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          dp_cmd_o.load = 1'b1;
          state_d       = S_FIND;
        end
      end
      S_FIND: begin
        dp_cmd_o.find = 1'b1;
        state_d       = S_EXEC;
      end
      S_EXEC: begin
        // hold until the result register can take the new item
        if (slot_free) begin
          dp_cmd_o.exec = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (dp_cmd_o.exec) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bal_datapath.sv
`default_nettype none

module bal_datapath (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire bal_pkg::dp_cmd_t                       dp_cmd_i,
  input  wire logic [bal_pkg::CMD_W-1:0]              cmd_i,
  input  wire logic [bal_pkg::POS_W-1:0]              pos_i,
  input  wire bal_pkg::rec_t                          rec_i,
  output bal_pkg::status_e                            status_o,
  output logic [bal_pkg::ENTRY_W-1:0]                 entry_count_o,
  output bal_pkg::rec_t                               rec_o
);

  localparam int CAP   = bal_pkg::CAPACITY;
  localparam int CNT_W = bal_pkg::CNT_W;
  localparam int IDX_W = bal_pkg::IDX_W;
  localparam int CMP_W = bal_pkg::CMP_W;

  bal_pkg::rec_t                 records_q [CAP];
  bal_pkg::rec_t                 records_d [CAP];
  logic [CNT_W-1:0]              count_q, count_d;
  bal_pkg::cmd_e                 cmd_q;
  logic [bal_pkg::POS_W-1:0]     pos_q;
  bal_pkg::rec_t                 rec_q;
  logic [CAP-1:0]                gt_q, gt_d;

  bal_pkg::status_e              status_q, status_d;
  logic [bal_pkg::ENTRY_W-1:0]   entry_q;
  bal_pkg::rec_t                 rd_q, rd_d;

  logic [CMP_W-1:0]              cnt_ext, slot, at;
  logic [IDX_W-1:0]              at_idx;
  logic                          is_ins, do_ins, do_del;

  // Compare every held age against the new one
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      gt_d[i] = (CNT_W'(i) < count_q) && (records_q[i].age > rec_q.age);
    end
  end

  // First entry with a greater age, or the rear when there is none
  always_comb begin
    slot = cnt_ext;
    for (int i = CAP - 1; i >= 0; i--) begin
      if (gt_q[i]) slot = CMP_W'(i);
    end
  end

  assign cnt_ext = CMP_W'(count_q);
  assign is_ins  = !cmd_q[bal_pkg::CMD_W-1];

  always_comb begin
    case (cmd_q)
      bal_pkg::CMD_INS_FRONT, bal_pkg::CMD_DEL_FRONT: at = '0;
      bal_pkg::CMD_INS_REAR:                          at = cnt_ext;
      bal_pkg::CMD_DEL_REAR:                          at = cnt_ext - CMP_W'(1);
      bal_pkg::CMD_INS_SORTED:                        at = slot;
      default:                                        at = CMP_W'(pos_q);
    endcase
  end

  assign at_idx = at[IDX_W-1:0];

  always_comb begin
    status_d = bal_pkg::ST_OK;
    if (is_ins) begin
      if (count_q == CNT_W'(CAP))  status_d = bal_pkg::ST_FULL;
      else if (at > cnt_ext)       status_d = bal_pkg::ST_RANGE;
    end else begin
      if (count_q == '0)           status_d = bal_pkg::ST_EMPTY;
      else if (at >= cnt_ext)      status_d = bal_pkg::ST_RANGE;
    end
  end

  assign do_ins = dp_cmd_i.exec && is_ins && (status_d == bal_pkg::ST_OK);
  assign do_del = dp_cmd_i.exec && !is_ins && (cmd_q != bal_pkg::CMD_READ) &&
                  (status_d == bal_pkg::ST_OK);

  // Shift the chain from the target on: right to open a gap, left to close one
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      records_d[i] = records_q[i];
      if (do_ins) begin
        if (CMP_W'(i) == at)                 records_d[i] = rec_q;
        else if (i > 0 && CMP_W'(i) > at)    records_d[i] = records_q[(i > 0) ? i - 1 : 0];
      end else if (do_del) begin
        if (i < CAP - 1 && CMP_W'(i) >= at)  records_d[i] = records_q[(i < CAP - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) count_d = count_q + CNT_W'(1);
    if (do_del) count_d = count_q - CNT_W'(1);
  end

  always_comb begin
    rd_d = '0;
    if (cmd_q == bal_pkg::CMD_READ && status_d == bal_pkg::ST_OK) rd_d = records_q[at_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAP; i++) records_q[i] <= records_d[i];
    if (dp_cmd_i.load) begin
      cmd_q <= bal_pkg::cmd_e'(cmd_i);
      pos_q <= pos_i;
      rec_q <= rec_i;
    end
    if (dp_cmd_i.find) gt_q <= gt_d;
    if (dp_cmd_i.exec) begin
      status_q <= status_d;
      entry_q  <= bal_pkg::ENTRY_W'(CMP_W'(count_d));
      rd_q     <= rd_d;
    end
  end

  assign status_o      = status_q;
  assign entry_count_o = entry_q;
  assign rec_o         = rd_q;

endmodule

`default_nettype wire

// File: rtl/bounded_array_list.sv
// Bounded ordered list of records with insert, delete and read by position.
// An accepted item is captured, its age compares are registered, and then the
// shift and result are written; no new item is taken before that result is written.
// A waiting result does not block capture of the next item; that item holds in
// the execute step until the output register drains.
// Reset (async, active low) empties the list and drops any pending result;
// record storage itself is not cleared.
`default_nettype none

module bounded_array_list (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // tdata from bit 0: position[5:0], age_in[13:6], id_in[44:14],
  // month_in[48:45], day_in[53:49], year_in[65:54], zero fill
  input  wire logic [bal_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // tuser from bit 0: cmd[2:0], zero fill
  input  wire logic [bal_pkg::IN_USER_W-1:0]      s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // tdata from bit 0: status[1:0], entry_count[7:2], age_out[15:8],
  // id_out[46:16], month_out[50:47], day_out[55:51], year_out[67:56], zero fill
  output logic [bal_pkg::OUT_DATA_W-1:0]          m_axis_tdata
);

  bal_pkg::dp_cmd_t              dp_cmd;
  bal_pkg::status_e              status;
  logic [bal_pkg::ENTRY_W-1:0]   entry_count;
  bal_pkg::rec_t                 rec_out;
  bal_pkg::rec_t                 rec_in;

  // Unpack the incoming record, fields sit right after position
  assign rec_in = s_axis_tdata[bal_pkg::POS_W +: $bits(bal_pkg::rec_t)];

  // Controller: sequence capture, compare and execute; own the result valid
  bal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .dp_cmd_o    (dp_cmd)
  );

  // Datapath: register chain of records, count, and result register
  bal_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dp_cmd_i      (dp_cmd),
    .cmd_i         (s_axis_tuser[bal_pkg::CMD_W-1:0]),
    .pos_i         (s_axis_tdata[bal_pkg::POS_W-1:0]),
    .rec_i         (rec_in),
    .status_o      (status),
    .entry_count_o (entry_count),
    .rec_o         (rec_out)
  );

  // Pack the result item, zero fill to whole bytes
  assign m_axis_tdata = {
    {(bal_pkg::OUT_DATA_W - bal_pkg::STATUS_W - bal_pkg::ENTRY_W
      - $bits(bal_pkg::rec_t)){1'b0}},
    rec_out, entry_count, status
  };

  // A result is written only into a free or draining output register
  a_exec_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.exec |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result written over a pending item");

  // An accepted item blocks further input for the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // Full status only with a full list
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status == bal_pkg::ST_FULL) |->
      (entry_count == bal_pkg::ENTRY_W'(bal_pkg::CAPACITY)))
    else $error("full status with a list that is not full");

  // Empty status only with an empty list
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status == bal_pkg::ST_EMPTY) |-> (entry_count == '0))
    else $error("empty status with a list that is not empty");

endmodule

`default_nettype wire

// File: bench/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bal_pkg::*;

  // One command as sent to the list, and the reply it should produce
  typedef struct packed {
    cmd_e              cmd;
    logic [POS_W-1:0]  pos;
    rec_t              rec;
  } list_op_t;

  typedef struct packed {
    status_e            status;
    logic [ENTRY_W-1:0] count;
    rec_t               rec;
  } list_reply_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // tdata from bit 0: position, age_in, id_in, month_in, day_in, year_in, zero fill
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  // tuser from bit 0: cmd, zero fill
  logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // tdata from bit 0: status, entry_count, age_out, id_out, month_out, day_out,
  // year_out, zero fill
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  bounded_array_list u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Shadow of the list contents and fill level
  rec_t list_mem [CAPACITY];
  int   list_count = 0;
  int   peak_count = 0;

  list_op_t    pending_ops[$];
  list_reply_t expected_replies[$];
  list_op_t    drv_op;

  bit item_taken   = 1'b0;
  bit result_taken = 1'b0;
  bit steady       = 1'b0;  // no idling on either side while set
  int send_gap     = 0;
  int hold_cycles  = 0;
  int items_taken  = 0;
  int results_seen = 0;
  int fault_count  = 0;
  int status_hits [4];

  // Apply one command to the shadow list and return the reply it causes
  function automatic list_reply_t apply_op(list_op_t op);
    list_reply_t rsp;
    int at;
    rsp        = '0;
    rsp.status = ST_OK;
    at         = 0;
    case (op.cmd)
      CMD_INS_FRONT, CMD_INS_REAR, CMD_INS_INDEX, CMD_INS_SORTED: begin
        if (list_count >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else begin
          case (op.cmd)
            CMD_INS_FRONT: at = 0;
            CMD_INS_REAR:  at = list_count;
            CMD_INS_INDEX: at = op.pos;
            default: begin
              // stable: land before the first strictly older entry
              at = list_count;
              for (int i = list_count - 1; i >= 0; i--)
                if (list_mem[i].age > op.rec.age) at = i;
            end
          endcase
          if (at > list_count) begin
            rsp.status = ST_RANGE;
          end else begin
            for (int i = list_count; i > at; i--) list_mem[i] = list_mem[i-1];
            list_mem[at] = op.rec;
            list_count++;
          end
        end
      end
      default: begin
        if (list_count == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          case (op.cmd)
            CMD_DEL_FRONT: at = 0;
            CMD_DEL_REAR:  at = list_count - 1;
            default:       at = op.pos;
          endcase
          if (at >= list_count) begin
            rsp.status = ST_RANGE;
          end else if (op.cmd == CMD_READ) begin
            rsp.rec = list_mem[at];
          end else begin
            for (int i = at; i + 1 < list_count; i++) list_mem[i] = list_mem[i+1];
            list_count--;
          end
        end
      end
    endcase
    rsp.count = ENTRY_W'(list_count);
    if (list_count > peak_count) peak_count = list_count;
    return rsp;
  endfunction

  function automatic void note_field(string name, longint unsigned want,
                                     longint unsigned got);
    if (want != got) begin
      fault_count++;
      if (fault_count <= 10)
        $display("%0t: reply %0d field %s expected 0x%0h got 0x%0h",
                 $realtime, results_seen, name, want, got);
    end
  endfunction

  function automatic rec_t rand_rec();
    rec_t r;
    r.age   = AGE_W'($urandom);
    r.id    = ID_W'($urandom);
    r.month = MONTH_W'($urandom);
    r.day   = DAY_W'($urandom);
    r.year  = YEAR_W'($urandom);
    return r;
  endfunction

  // Hand one command to the driver once it has taken the previous one
  task automatic queue_op(cmd_e cmd, int pos, rec_t rec);
    list_op_t op;
    op.cmd = cmd;
    op.pos = POS_W'(pos);
    op.rec = rec;
    while (pending_ops.size() != 0) @(posedge clk_i);
    pending_ops.push_back(op);
  endtask

  // Sample both handshakes at the rising edge: predict on the way in,
  // compare on the way out.
  always @(posedge clk_i) begin : watch_ports
    list_reply_t want;
    if (s_axis_tvalid && s_axis_tready) begin
      expected_replies.push_back(apply_op(drv_op));
      items_taken++;
      item_taken = 1'b1;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      result_taken = 1'b1;
      if (expected_replies.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: reply with nothing pending, data 0x%0h", $realtime, m_axis_tdata);
      end else begin
        want = expected_replies.pop_front();
        status_hits[want.status]++;
        note_field("status",    want.status,    m_axis_tdata[1:0]);
        note_field("count",     want.count,     m_axis_tdata[7:2]);
        note_field("age",       want.rec.age,   m_axis_tdata[15:8]);
        note_field("id",        want.rec.id,    m_axis_tdata[46:16]);
        note_field("month",     want.rec.month, m_axis_tdata[50:47]);
        note_field("day",       want.rec.day,   m_axis_tdata[55:51]);
        note_field("year",      want.rec.year,  m_axis_tdata[67:56]);
      end
    end
  end

  // Input side: drop valid after a taken item, wait out the drawn gap,
  // then present the next pending command.
  always @(negedge clk_i) begin : drive_items
    logic nxt_valid;
    nxt_valid = s_axis_tvalid;
    if (item_taken) begin
      item_taken = 1'b0;
      nxt_valid  = 1'b0;
    end
    if (rst_ni && !nxt_valid) begin
      if (send_gap != 0) begin
        send_gap--;
      end else if (pending_ops.size() != 0) begin
        drv_op = pending_ops.pop_front();
        s_axis_tdata <= IN_DATA_W'({drv_op.rec.year, drv_op.rec.day, drv_op.rec.month,
                                    drv_op.rec.id, drv_op.rec.age, drv_op.pos});
        s_axis_tuser <= IN_USER_W'(drv_op.cmd);
        nxt_valid = 1'b1;
        send_gap  = steady ? 0 : $urandom_range(0, 13);
      end
    end
    s_axis_tvalid <= nxt_valid;
  end

  // Output side: after each reply, hold ready low for a drawn stall
  always @(negedge clk_i) begin : drive_ready
    if (result_taken) begin
      result_taken = 1'b0;
      hold_cycles  = steady ? 0 : $urandom_range(0, 13);
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin : stimulus
    rec_t r;
    cmd_e cmd;
    int   pos;
    int   pick;
    bit   filling;
    filling = 1'b1;

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty-list errors, extremes, sorted ties, range checks
    queue_op(CMD_READ,      0,  rand_rec());
    queue_op(CMD_DEL_FRONT, 5,  rand_rec());
    queue_op(CMD_DEL_REAR,  63, rand_rec());
    queue_op(CMD_DEL_INDEX, 0,  rand_rec());
    queue_op(CMD_INS_INDEX, 1,  rand_rec());
    queue_op(CMD_INS_INDEX, 0,  '1);
    queue_op(CMD_INS_FRONT, 63, '0);
    r = rand_rec(); r.age = 8'h80;
    queue_op(CMD_INS_REAR, 0, r);
    r = rand_rec(); r.age = 8'h80;
    queue_op(CMD_INS_SORTED, 0, r);
    r = rand_rec(); r.age = 8'h80;
    queue_op(CMD_INS_SORTED, 0, r);
    r = rand_rec(); r.age = 8'hff;
    queue_op(CMD_INS_SORTED, 0, r);
    r = rand_rec(); r.age = 8'h00;
    queue_op(CMD_INS_SORTED, 0, r);
    queue_op(CMD_INS_INDEX, 7,  rand_rec());
    queue_op(CMD_INS_INDEX, 9,  rand_rec());
    queue_op(CMD_INS_INDEX, 63, rand_rec());
    queue_op(CMD_READ,      0,  rand_rec());
    queue_op(CMD_READ,      7,  rand_rec());
    queue_op(CMD_READ,      8,  rand_rec());
    queue_op(CMD_READ,      63, rand_rec());
    queue_op(CMD_DEL_INDEX, 8,  rand_rec());
    queue_op(CMD_DEL_INDEX, 63, rand_rec());
    queue_op(CMD_DEL_INDEX, 3,  rand_rec());
    queue_op(CMD_DEL_FRONT, 0,  rand_rec());
    queue_op(CMD_DEL_REAR,  0,  rand_rec());
    queue_op(CMD_READ,      4,  rand_rec());

    // Random: swing the fill level between empty and full so both limits
    // get hit repeatedly; positions mostly land near the live range.
    for (int n = 0; n < 1800; n++) begin
      if (n % 150 == 0) steady = ($urandom_range(0, 2) == 0);
      if (list_count >= CAPACITY && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (list_count == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      r = rand_rec();
      // narrow ages often so sorted inserts see ties
      if ($urandom_range(0, 3) == 0) r.age = AGE_W'($urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 63);
      else pos = $urandom_range(0, list_count + 1);
      pick = $urandom_range(0, 99);
      if (pick < 15) cmd = CMD_READ;
      else if (pick < (filling ? 80 : 35)) cmd = cmd_e'($urandom_range(0, 3));
      else cmd = cmd_e'($urandom_range(4, 6));
      queue_op(cmd, pos, r);
    end

    // Drain, then leave room for any stray reply
    while (pending_ops.size() != 0 || s_axis_tvalid || expected_replies.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d commands, checked %0d replies (ok %0d, full %0d, empty %0d, range %0d).",
             items_taken, results_seen, status_hits[ST_OK], status_hits[ST_FULL],
             status_hits[ST_EMPTY], status_hits[ST_RANGE]);
    $display("Peak fill %0d of %0d entries, %0d field mismatches.",
             peak_count, CAPACITY, fault_count);
    if (fault_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
rtl/bal_pkg.sv
rtl/bal_ctrl.sv
rtl/bal_datapath.sv
rtl/bounded_array_list.sv
bench/testbench.sv
